### design/bfpa_pkg.sv
// Shared types, constants and helpers for the best-fit partition allocator.
// No dependencies; imported by every module of the block.
package bfpa_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SIZE_BITS = 20;
    localparam int IDX_W     = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int FIELD_W   = 20;
    localparam int SUM_W     = 32;

    localparam logic [1:0] STAT_ALLOC    = 2'd0;
    localparam logic [1:0] STAT_NOFIT    = 2'd1;
    localparam logic [1:0] STAT_LOAD_OK  = 2'd2;
    localparam logic [1:0] STAT_LOAD_REJ = 2'd3;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [IDX_W-1:0]     t_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic  active;
        t_idx  pos;
        t_size want;
        logic  found;
        t_idx  best_idx;
        t_size best_size;
    } t_tok;

    typedef struct packed {
        logic  wr;
        logic  clr;
        t_size size;
        logic  free;
    } t_cell_ctl;

    function automatic t_size field_to_size(input logic [FIELD_W-1:0] x);
        logic [SIZE_BITS+FIELD_W-1:0] ext;
        ext = {{SIZE_BITS{1'b0}}, x};
        return ext[SIZE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] size_to_field(input t_size x);
        logic [SIZE_BITS+FIELD_W-1:0] ext;
        ext = {{FIELD_W{1'b0}}, x};
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [3:0] idx_to_field(input t_idx x);
        logic [IDX_W+3:0] ext;
        ext = {4'b0000, x};
        return ext[3:0];
    endfunction

endpackage

### design/best_fit_partition_allocator.sv
// Top level of the best-fit partition allocator: control, load bookkeeping,
// result register and the row of partition cells. Depends on bfpa_pkg, bfpa_cell.
//
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_opcode, i_item_size, i_start_free
// result    out        o_out_valid / i_out_ready  o_status, o_slot_index, o_waste,
//                                                 o_waste_total
// config    in         i_cfg_we                   i_cfg_wdata (memory_size)
//
// A load goes from idle straight to the finish step; an allocation passes through the
// scan state while the search record walks the cell row one cell per cycle.
// One request is in flight at a time; a new one is taken while the last result
// still waits in the output register, and the finish step holds on a full one.
// Reset is synchronous, active low, and clears all free marks and counters.
module best_fit_partition_allocator
    import bfpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [FIELD_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  logic [FIELD_W-1:0]  i_item_size,
    input  logic                i_start_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [3:0]          o_slot_index,
    output logic [FIELD_W-1:0]  o_waste,
    output logic [SUM_W-1:0]    o_waste_total
);

    t_state r_state;
    t_state n_state;

    logic             r_op;
    t_size            r_want;
    logic             r_start_free;
    logic             r_found;
    t_idx             r_best_idx;
    t_size            r_best_size;
    logic [CNT_W-1:0] r_count;
    t_size            r_covered;
    logic             r_closed;
    logic [SUM_W-1:0] r_sum;
    t_size            r_mem_size;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [3:0]         r_slot;
    logic [FIELD_W-1:0] r_waste;

    logic s_accept;
    logic s_go;
    logic s_inject;

    t_tok      s_head;
    t_tok      s_tok [MAX_SLOTS+1];
    t_cell_ctl s_ctl [MAX_SLOTS];

    logic             s_reject;
    t_size            s_room;
    logic             s_clip;
    t_size            s_load_size;
    t_size            s_waste;
    logic [SUM_W:0]   s_sum_ext;
    logic [SUM_W-1:0] s_sum_sat;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_REQUEST) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (s_tok[MAX_SLOTS].active) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        s_go       = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_SCAN:   o_in_ready = 1'b0;
            ST_FINISH: s_go       = !r_out_valid || i_out_ready;
            default:   o_in_ready = 1'b0;
        endcase
        s_accept = o_in_ready && i_in_valid;
        s_inject = s_accept && (i_opcode == OP_REQUEST);
    end

    always_comb begin
        s_head.active    = s_inject;
        s_head.pos       = '0;
        s_head.want      = field_to_size(i_item_size);
        s_head.found     = 1'b0;
        s_head.best_idx  = '0;
        s_head.best_size = '0;
    end

    assign s_tok[0] = s_head;

    always_comb begin
        s_reject    = r_closed || (r_count >= CNT_W'(MAX_SLOTS));
        s_room      = (r_covered < r_mem_size) ? (r_mem_size - r_covered) : '0;
        s_clip      = r_want > s_room;
        s_load_size = s_clip ? s_room : r_want;
        s_waste     = r_best_size - r_want;
        s_sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(s_waste);
        s_sum_sat   = s_sum_ext[SUM_W] ? {SUM_W{1'b1}} : s_sum_ext[SUM_W-1:0];
    end

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            s_ctl[i].wr   = s_go && (r_op == OP_LOAD) && !s_reject
                            && (r_count[IDX_W-1:0] == t_idx'(i));
            s_ctl[i].clr  = s_go && (r_op == OP_REQUEST) && r_found
                            && (r_best_idx == t_idx'(i));
            s_ctl[i].size = s_load_size;
            s_ctl[i].free = r_start_free;
        end
    end

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        bfpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[g]),
            .i_tok   (s_tok[g]),
            .o_tok   (s_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op         <= i_opcode;
            r_want       <= field_to_size(i_item_size);
            r_start_free <= i_start_free;
        end
        if (s_tok[MAX_SLOTS].active) begin
            r_found     <= s_tok[MAX_SLOTS].found;
            r_best_idx  <= s_tok[MAX_SLOTS].best_idx;
            r_best_size <= s_tok[MAX_SLOTS].best_size;
        end
        if (s_go) begin
            if (r_op == OP_LOAD) begin
                r_status <= s_reject ? STAT_LOAD_REJ : STAT_LOAD_OK;
                r_slot   <= s_reject ? 4'd0 : idx_to_field(r_count[IDX_W-1:0]);
                r_waste  <= '0;
            end else begin
                r_status <= r_found ? STAT_ALLOC : STAT_NOFIT;
                r_slot   <= r_found ? idx_to_field(r_best_idx) : 4'd0;
                r_waste  <= r_found ? size_to_field(s_waste) : '0;
            end
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_covered   <= '0;
            r_closed    <= 1'b0;
            r_sum       <= '0;
            r_mem_size  <= field_to_size(20'hFFFFF);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mem_size <= field_to_size(i_cfg_wdata);
            end
            if (s_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s_go && (r_op == OP_LOAD) && !s_reject) begin
                r_count   <= r_count + CNT_W'(1);
                r_covered <= r_covered + s_load_size;
                r_closed  <= r_closed || s_clip;
            end
            if (s_go && (r_op == OP_REQUEST) && r_found) begin
                r_sum <= s_sum_sat;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot;
    assign o_waste       = r_waste;
    assign o_waste_total = r_sum;

`ifndef SYNTHESIS
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tok[MAX_SLOTS].active |-> (r_state == ST_SCAN))
        else $error("search record left the cell row outside a scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SLOTS))
        else $error("partition count beyond table size");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_sum >= $past(r_sum)))
        else $error("fragmentation total decreased");

    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !s_tok[MAX_SLOTS].active)
        else $error("search record active while idle");
`endif

endmodule

### design/bfpa_cell.sv
// One partition cell: holds a size and a free mark, and passes the best-fit
// search record to its neighbor each cycle. Depends on bfpa_pkg.
module bfpa_cell
    import bfpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_tok      i_tok,
    output t_tok      o_tok
);

    t_size r_size;
    logic  r_free;
    t_tok  r_tok;
    t_tok  n_tok;
    logic  s_take;

    always_comb begin
        s_take = i_tok.active && r_free && (r_size >= i_tok.want)
                 && (!i_tok.found || (r_size <= i_tok.best_size));
        n_tok     = i_tok;
        n_tok.pos = i_tok.pos + t_idx'(1);
        if (s_take) begin
            n_tok.found     = 1'b1;
            n_tok.best_idx  = i_tok.pos;
            n_tok.best_size = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_size <= i_ctl.size;
        end
        if (!i_rst_n) begin
            r_free <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_ctl.wr) begin
                r_free <= i_ctl.free;
            end else if (i_ctl.clr) begin
                r_free <= 1'b0;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for best_fit_partition_allocator: directed table, then random loads
// and requests checked against an in-bench best-fit model. Depends on bfpa_pkg and the RTL.
module tb;
    import bfpa_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DIR_ROWS    = 17;
    localparam int PHASE_ITEMS = 350;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         slot;
        logic [FIELD_W-1:0] waste;
        logic [SUM_W-1:0]   total;
    } t_outcome;

    typedef struct packed {
        logic               set_mem;
        logic [FIELD_W-1:0] mem_val;
        logic               op;
        logic [FIELD_W-1:0] size;
        logic               free;
        logic               typed;
        t_outcome           expd;
    } t_step;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [FIELD_W-1:0] i_cfg_wdata  = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic               i_opcode     = OP_LOAD;
    logic [FIELD_W-1:0] i_item_size  = '0;
    logic               i_start_free = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic [1:0]         o_status;
    logic [3:0]         o_slot_index;
    logic [FIELD_W-1:0] o_waste;
    logic [SUM_W-1:0]   o_waste_total;

    t_size              part_size [MAX_SLOTS];
    logic               part_free [MAX_SLOTS] = '{default: 1'b0};
    logic [CNT_W-1:0]   part_count    = '0;
    t_size              covered_units = '0;
    logic               load_closed   = 1'b0;
    logic [SUM_W-1:0]   waste_sum     = '0;
    t_size              mem_limit     = 20'hFFFFF;

    t_outcome           expected_q [$];
    int                 error_count   = 0;
    int                 cycle_count   = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    t_step directed_steps [DIR_ROWS] = '{
        '{1'b0, 20'd0, OP_REQUEST, 20'hFFFFF, 1'b1, 1'b1, '{STAT_NOFIT, 4'd0, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_REQUEST, 20'd0, 1'b0, 1'b1, '{STAT_NOFIT, 4'd0, 20'd0, 32'd0}},
        '{1'b1, 20'd0, OP_LOAD, 20'd0, 1'b1, 1'b1, '{STAT_LOAD_OK, 4'd0, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_REQUEST, 20'd0, 1'b1, 1'b1, '{STAT_ALLOC, 4'd0, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_REQUEST, 20'd0, 1'b1, 1'b1, '{STAT_NOFIT, 4'd0, 20'd0, 32'd0}},
        '{1'b1, 20'hFFFFF, OP_LOAD, 20'd100, 1'b1, 1'b1,
          '{STAT_LOAD_OK, 4'd1, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_LOAD, 20'd100, 1'b1, 1'b1, '{STAT_LOAD_OK, 4'd2, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_LOAD, 20'd300, 1'b0, 1'b1, '{STAT_LOAD_OK, 4'd3, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_LOAD, 20'd200, 1'b1, 1'b1, '{STAT_LOAD_OK, 4'd4, 20'd0, 32'd0}},
        '{1'b0, 20'd0, OP_REQUEST, 20'd100, 1'b0, 1'b0, '0},
        '{1'b0, 20'd0, OP_REQUEST, 20'd50, 1'b1, 1'b0, '0},
        '{1'b0, 20'd0, OP_REQUEST, 20'd150, 1'b0, 1'b0, '0},
        '{1'b0, 20'd0, OP_REQUEST, 20'd250, 1'b1, 1'b0, '0},
        '{1'b0, 20'd0, OP_REQUEST, 20'd1, 1'b0, 1'b0, '0},
        '{1'b0, 20'd0, OP_LOAD, 20'd1000, 1'b1, 1'b0, '0},
        '{1'b0, 20'd0, OP_REQUEST, 20'h80000, 1'b1, 1'b0, '0},
        '{1'b0, 20'd0, OP_REQUEST, 20'd999, 1'b0, 1'b0, '0}
    };

    best_fit_partition_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_item_size   (i_item_size),
        .i_start_free  (i_start_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_waste       (o_waste),
        .o_waste_total (o_waste_total)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_outcome best_fit_outcome(input logic op, input t_size want,
                                                  input logic fr);
        t_outcome         r;
        t_size            room;
        t_size            stored;
        logic             found;
        t_idx             best;
        logic [SUM_W:0]   acc;
        r     = '0;
        found = 1'b0;
        best  = '0;
        if (op == OP_LOAD) begin
            room = (covered_units < mem_limit) ? mem_limit - covered_units : '0;
            if (load_closed || part_count >= MAX_SLOTS) begin
                r.status = STAT_LOAD_REJ;
            end else begin
                stored = want;
                if (want > room) begin
                    stored      = room;
                    load_closed = 1'b1;
                end
                part_size[part_count[IDX_W-1:0]] = stored;
                part_free[part_count[IDX_W-1:0]] = fr;
                covered_units         = covered_units + stored;
                r.status              = STAT_LOAD_OK;
                r.slot                = part_count[3:0];
                part_count            = part_count + 1'b1;
            end
        end else begin
            for (int i = 0; i < part_count; i++) begin
                if (part_free[i[IDX_W-1:0]] && part_size[i[IDX_W-1:0]] >= want &&
                    (!found || part_size[i[IDX_W-1:0]] <= part_size[best])) begin
                    best  = i[IDX_W-1:0];
                    found = 1'b1;
                end
            end
            if (!found) begin
                r.status = STAT_NOFIT;
            end else begin
                part_free[best] = 1'b0;
                r.status        = STAT_ALLOC;
                r.slot          = idx_to_field(best);
                r.waste         = part_size[best] - want;
                acc             = {1'b0, waste_sum} + (SUM_W+1)'(r.waste);
                waste_sum       = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
            end
        end
        r.total = waste_sum;
        return r;
    endfunction

    task automatic send_request(input logic op, input logic [FIELD_W-1:0] sz, input logic fr,
                                input logic typed, input t_outcome typed_val);
        int       gap;
        t_outcome predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_item_size  <= sz;
        i_start_free <= fr;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = best_fit_outcome(op, sz, fr);
        expected_q.push_back(typed ? typed_val : predicted);
    endtask

    task automatic set_memory_size(input logic [FIELD_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mem_limit    = value;
    endtask

    task automatic note_failure(input string what, input t_outcome want, input t_outcome got);
        error_count++;
        if (error_count <= 10)
            $display("%0t %s: status %0d/%0d slot %0d/%0d waste %0d/%0d total %0d/%0d",
                     $realtime, what, want.status, got.status, want.slot, got.slot,
                     want.waste, got.waste, want.total, got.total);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_slot_index, o_waste, o_waste_total};
            if (expected_q.size() == 0) begin
                note_failure("result with no request pending", 'x, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    note_failure("mismatch expected/actual", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** best_fit_partition_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        logic               clip_mode;
        logic               op;
        logic               fr;
        logic [FIELD_W-1:0] sz;
        logic [FIELD_W-1:0] mem_val;
        int                 pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 52;
        foreach (directed_steps[n]) begin
            if (directed_steps[n].set_mem)
                set_memory_size(directed_steps[n].mem_val);
            send_request(directed_steps[n].op, directed_steps[n].size, directed_steps[n].free,
                         directed_steps[n].typed, directed_steps[n].expd);
        end
        clip_mode = 1'($urandom_range(0, 1));
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 52;
                    mem_val = FIELD_W'(covered_units + $urandom_range(70000, 200000));
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 33;
                    mem_val = 20'hFFFFF;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    mem_val = clip_mode ? (covered_units >> 1)
                                        : FIELD_W'(covered_units + 65536);
                end
            endcase
            set_memory_size(mem_val);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 31) == 0) begin
                    op = OP_LOAD;
                    fr = ($urandom_range(0, 3) != 0);
                    if (clip_mode && $urandom_range(0, 3) == 0)
                        sz = FIELD_W'($urandom_range(0, 20'hFFFFF));
                    else if (part_count != 0 && $urandom_range(0, 2) == 0)
                        sz = part_size[IDX_W'($urandom_range(0, part_count - 1))];
                    else
                        sz = FIELD_W'($urandom_range(0, 4095));
                end else begin
                    op   = OP_REQUEST;
                    fr   = 1'($urandom_range(0, 1));
                    pick = $urandom_range(0, 3);
                    if (pick < 2 && part_count != 0) begin
                        sz = part_size[IDX_W'($urandom_range(0, part_count - 1))];
                        if (sz > 2)
                            sz = FIELD_W'(sz - $urandom_range(0, 2));
                    end else if (pick == 2) begin
                        sz = FIELD_W'($urandom_range(0, 4095));
                    end else begin
                        sz = FIELD_W'($urandom_range(0, 20'hFFFFF));
                    end
                end
                send_request(op, sz, fr, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("** best_fit_partition_allocator: PASSED **");
        else
            $display("** best_fit_partition_allocator: FAILED **");
        $finish;
    end
endmodule
